// ===== src/overwriting_audit_log_core_defines.svh =====
// Assertion macros for the audit log core.
// Each macro takes a label, clock, active-low reset and the expressions to check.
`ifndef OVERWRITING_AUDIT_LOG_CORE_DEFINES_SVH
`define OVERWRITING_AUDIT_LOG_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define AOL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("audit log: implication check failed");

`define AOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("audit log: next-cycle check failed");

`else

`define AOL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define AOL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/aol_pkg.sv =====
`timescale 1ns / 1ps

package aol_pkg;

  // Default log depth.
  localparam int LOG_DEPTH_DEF = 16;

  // Command queue between front and back.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Result queue at the output.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_code_t;

  typedef struct packed {
    logic [15:0]        req_tag;
    logic [15:0]        cmd_tag;
    logic signed [15:0] result_code;
    logic [15:0]        detail;
    logic [31:0]        timestamp_ms;
  } entry_t;

  typedef struct packed {
    logic       is_read;
    logic       want_zero;
    entry_t     entry;
    logic [7:0] read_limit;
  } cmd_item_t;

  typedef struct packed {
    entry_t entry;
    logic   empty_res;
    logic   last;
  } out_item_t;

endpackage

// ===== src/aol_front.sv =====
`timescale 1ns / 1ps

module aol_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic                in_cmd,
  input  logic [15:0]         in_req_tag,
  input  logic [15:0]         in_cmd_tag,
  input  logic signed [15:0]  in_result_code,
  input  logic [15:0]         in_detail,
  input  logic [31:0]         in_timestamp_ms,
  input  logic [7:0]          in_read_limit,
  output logic                cmd_valid,
  output aol_pkg::cmd_item_t  cmd_item,
  input  logic                cmd_pop
);

  import aol_pkg::*;

  cmd_item_t             q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  cmd_item_t             new_item;
  logic                  do_push;
  logic                  do_pop;

  // classify on entry
  always_comb begin
    new_item.is_read            = (cmd_code_t'(in_cmd) == CMD_READ);
    new_item.want_zero          = (in_read_limit == 8'd0);
    new_item.entry.req_tag      = in_req_tag;
    new_item.entry.cmd_tag      = in_cmd_tag;
    new_item.entry.result_code  = in_result_code;
    new_item.entry.detail       = in_detail;
    new_item.entry.timestamp_ms = in_timestamp_ms;
    new_item.read_limit         = in_read_limit;
  end

  assign full      = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd_item  = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + CMDQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + CMDQ_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CMDQ_CNT_W'(do_push) - CMDQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== src/aol_outq.sv =====
`timescale 1ns / 1ps

module aol_outq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           res_push,
  input  aol_pkg::out_item_t             res_item,
  input  logic                           pop,
  output logic                           empty,
  output aol_pkg::out_item_t             head_item,
  output logic [aol_pkg::OUT_CNT_W-1:0]  cnt
);

  import aol_pkg::*;

  out_item_t            q_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_pop;

  assign empty     = (cnt_r == '0);
  assign cnt       = cnt_r;
  assign head_item = q_r[rd_ptr_r];
  assign do_pop    = pop && !empty;

  // back end never pushes into a full queue (credit check upstream)
  always_comb begin
    wr_ptr_nxt = res_push ? wr_ptr_r + OUT_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + OUT_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + OUT_CNT_W'(res_push) - OUT_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wr_ptr_r] <= res_item;
    end
  end

endmodule

// ===== src/aol_back.sv =====
`timescale 1ns / 1ps

module aol_back #(
  parameter int LOG_DEPTH = aol_pkg::LOG_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_valid,
  input  aol_pkg::cmd_item_t             cmd_item,
  output logic                           cmd_pop,
  input  logic [aol_pkg::OUT_CNT_W-1:0]  out_cnt,
  output logic                           res_push,
  output aol_pkg::out_item_t             res_item
);

  import aol_pkg::*;

  `include "overwriting_audit_log_core_defines.svh"

  localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int SUM_W = $clog2(2 * LOG_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } bk_state_t;

  entry_t      mem [LOG_DEPTH];
  entry_t      mem_q_r;

  bk_state_t   state_r, state_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic        rd_vld_r, rd_vld_nxt;
  logic        rd_empty_r, rd_empty_nxt;
  logic        rd_last_r, rd_last_nxt;

  logic        mem_we;
  logic        mem_rd;
  logic        room;
  logic [CNT_W-1:0] n_c;
  logic [SUM_W-1:0] sum_c;
  logic [PTR_W-1:0] start_c;

  // entries to return: min(read_limit, fill)
  always_comb begin
    if (cmd_item.want_zero) begin
      n_c = '0;
    end else if (cmd_item.read_limit >= 8'(fill_r)) begin
      n_c = fill_r;
    end else begin
      n_c = CNT_W'(cmd_item.read_limit);
    end
  end

  // oldest entry of the window: head - n, modulo depth
  always_comb begin
    sum_c = SUM_W'(head_r) + SUM_W'(LOG_DEPTH) - SUM_W'(n_c);
    if (sum_c >= SUM_W'(LOG_DEPTH)) begin
      start_c = PTR_W'(sum_c - SUM_W'(LOG_DEPTH));
    end else begin
      start_c = PTR_W'(sum_c);
    end
  end

  // credit: queued results plus the one in flight must leave a slot
  assign room = ((out_cnt + OUT_CNT_W'(rd_vld_r)) < OUT_CNT_W'(OUT_DEPTH));

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    addr_nxt     = addr_r;
    remain_nxt   = remain_r;
    cmd_pop      = 1'b0;
    mem_we       = 1'b0;
    mem_rd       = 1'b0;
    rd_vld_nxt   = 1'b0;
    rd_empty_nxt = 1'b0;
    rd_last_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (!cmd_item.is_read) begin
            mem_we   = 1'b1;
            cmd_pop  = 1'b1;
            head_nxt = (head_r == PTR_W'(LOG_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
            if (fill_r != CNT_W'(LOG_DEPTH)) begin
              fill_nxt = fill_r + CNT_W'(1);
            end
          end else if (room) begin
            cmd_pop = 1'b1;
            if (n_c == '0) begin
              rd_vld_nxt   = 1'b1;
              rd_empty_nxt = 1'b1;
              rd_last_nxt  = 1'b1;
            end else begin
              state_nxt  = S_READ;
              addr_nxt   = start_c;
              remain_nxt = n_c;
            end
          end
        end
      end
      S_READ: begin
        if (room) begin
          mem_rd      = 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (remain_r == CNT_W'(1));
          addr_nxt    = (addr_r == PTR_W'(LOG_DEPTH - 1)) ? '0 : addr_r + PTR_W'(1);
          remain_nxt  = remain_r - CNT_W'(1);
          if (remain_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      fill_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    remain_r   <= remain_nxt;
    rd_empty_r <= rd_empty_nxt;
    rd_last_r  <= rd_last_nxt;
  end

  // log store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head_r] <= cmd_item.entry;
    end
    if (mem_rd) begin
      mem_q_r <= mem[addr_r];
    end
  end

  assign res_push           = rd_vld_r;
  assign res_item.entry     = rd_empty_r ? '0 : mem_q_r;
  assign res_item.empty_res = rd_empty_r;
  assign res_item.last      = rd_last_r;

  `AOL_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CNT_W'(LOG_DEPTH))
  `AOL_ASSERT_IMPLY(a_head_bound, clk, rst_n, 1'b1, head_r <= PTR_W'(LOG_DEPTH - 1))
  `AOL_ASSERT_IMPLY(a_read_remain, clk, rst_n, state_r == S_READ, remain_r != '0)
  `AOL_ASSERT_IMPLY(a_no_overflow, clk, rst_n, rd_vld_r, out_cnt < OUT_CNT_W'(OUT_DEPTH))
  `AOL_ASSERT_NEXT(a_last_idle, clk, rst_n, mem_rd && rd_last_nxt, state_r == S_IDLE)

endmodule

// ===== src/overwriting_audit_log_core.sv =====
// Path: a read's first result passes the front queue, the back end's read state,
//   the registered store read and the result queue; a read that yields nothing
//   skips the read state and the store read. A record makes one store write.
//   A read sets up its walk, then makes one store read per cycle while the
//   result queue has room; the back end takes no new command until the walk ends.
// Reset: synchronous, active low; clears queues, head pointer and fill count.
`timescale 1ns / 1ps

module overwriting_audit_log_core #(
  parameter int LOG_DEPTH = aol_pkg::LOG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               push,
  output logic               full,
  input  logic               in_cmd,
  input  logic [15:0]        in_req_tag,
  input  logic [15:0]        in_cmd_tag,
  input  logic signed [15:0] in_result_code,
  input  logic [15:0]        in_detail,
  input  logic [31:0]        in_timestamp_ms,
  input  logic [7:0]         in_read_limit,
  // result channel
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        out_req_tag,
  output logic [15:0]        out_cmd_tag,
  output logic signed [15:0] out_result_code,
  output logic [15:0]        out_detail,
  output logic [31:0]        out_timestamp_ms,
  output logic               out_empty_res,
  output logic               out_last
);

  import aol_pkg::*;

  // Structure:
  //   front - takes the input transfer, tags record vs read, and flags a
  //           zero-length read; holds up to two commands.
  //   back  - owns the log store, head pointer and fill count. A record
  //           writes at the head and advances it with wrap. A read computes
  //           n = min(read_limit, fill), starts at head - n and walks forward
  //           one entry per cycle while outq has room, marking the final one.
  //           An empty read emits a single zeroed result with the empty flag set.
  //   outq  - four-entry result queue; the back end only issues a store read
  //           when a slot is free counting the one already in flight.
  // Commands run one at a time in the back end, so a record queued behind a
  // read cannot overwrite entries the read still has to return.

  logic                 cmd_valid;
  cmd_item_t            cmd_item;
  logic                 cmd_pop;
  logic                 res_push;
  out_item_t            res_item;
  out_item_t            head_item;
  logic [OUT_CNT_W-1:0] out_cnt;

  aol_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_cmd          (in_cmd),
    .in_req_tag      (in_req_tag),
    .in_cmd_tag      (in_cmd_tag),
    .in_result_code  (in_result_code),
    .in_detail       (in_detail),
    .in_timestamp_ms (in_timestamp_ms),
    .in_read_limit   (in_read_limit),
    .cmd_valid       (cmd_valid),
    .cmd_item        (cmd_item),
    .cmd_pop         (cmd_pop)
  );

  aol_back #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_item  (cmd_item),
    .cmd_pop   (cmd_pop),
    .out_cnt   (out_cnt),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  aol_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_item  (res_item),
    .pop       (pop),
    .empty     (empty),
    .head_item (head_item),
    .cnt       (out_cnt)
  );

  // result transfer fields
  assign out_req_tag      = head_item.entry.req_tag;
  assign out_cmd_tag      = head_item.entry.cmd_tag;
  assign out_result_code  = head_item.entry.result_code;
  assign out_detail       = head_item.entry.detail;
  assign out_timestamp_ms = head_item.entry.timestamp_ms;
  assign out_empty_res    = head_item.empty_res;
  assign out_last         = head_item.last;

endmodule
